// ===== sv/vkf_pkg.sv =====
`default_nettype none
package vkf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int DT_W        = 17;
    localparam int VAR_W       = 31;

    localparam logic signed [31:0] COV_ONE = 32'(64'(1) << FRAC_BITS);
    localparam logic signed [31:0] COV_CAP = 32'(64'(15) << FRAC_BITS);
    localparam logic [DT_W-1:0]    DT_RESET = DT_W'(655);
    localparam logic [VAR_W-1:0]   VAR_RESET = VAR_W'(64'(1) << FRAC_BITS);

    typedef enum logic [1:0] {
        REQ_ENC  = 2'd0,
        REQ_GYRO = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_TIME_STEP      = 3'd0,
        CFG_PROC_VEL       = 3'd1,
        CFG_PROC_RATE      = 3'd2,
        CFG_PROC_ACCEL     = 3'd3,
        CFG_PROC_RATE_DOT  = 3'd4,
        CFG_ENC_VEL        = 3'd5,
        CFG_ENC_RATE       = 3'd6,
        CFG_GYRO_RATE      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] meas_vel;
        logic signed [31:0] meas_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] est_vel;
        logic signed [31:0] est_rate;
        logic signed [31:0] est_accel;
        logic signed [31:0] est_rate_dot;
        logic               had_measurement;
    } t_out;

    typedef struct packed {
        logic [DT_W-1:0]  time_step;
        logic [VAR_W-1:0] proc_noise_vel;
        logic [VAR_W-1:0] proc_noise_rate;
        logic [VAR_W-1:0] proc_noise_accel;
        logic [VAR_W-1:0] proc_noise_rate_dot;
        logic [VAR_W-1:0] enc_noise_vel;
        logic [VAR_W-1:0] enc_noise_rate;
        logic [VAR_W-1:0] gyro_noise_rate;
    } t_cfg;

    // one queued tick with the samples that were pending when it arrived
    typedef struct packed {
        logic               enc;
        logic               gyro;
        logic signed [31:0] enc_vel;
        logic signed [31:0] enc_rate;
        logic signed [31:0] gyro_rate;
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] res;
        if (v > 68'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] cap_cov(input logic signed [31:0] v);
        return (v > COV_CAP) ? COV_CAP : v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vkf_front.sv =====
`default_nettype none
module vkf_front import vkf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic               r_enc;
    logic               r_gyro;
    logic signed [31:0] r_enc_vel;
    logic signed [31:0] r_enc_rate;
    logic signed [31:0] r_gyro_rate;
    logic               w_tick;
    logic               w_acc;

    assign w_tick  = (i_data.req_type == REQ_TICK);
    // samples are always taken, a tick needs a queue slot
    assign o_ready = !(w_tick && i_q_full);
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc && w_tick;
    assign o_cmd   = '{enc: r_enc, gyro: r_gyro, enc_vel: r_enc_vel,
                       enc_rate: r_enc_rate, gyro_rate: r_gyro_rate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc       <= 1'b0;
            r_gyro      <= 1'b0;
            r_enc_vel   <= '0;
            r_enc_rate  <= '0;
            r_gyro_rate <= '0;
        end else if (w_acc) begin
            case (i_data.req_type)
                REQ_ENC: begin
                    r_enc_vel  <= i_data.meas_vel;
                    r_enc_rate <= i_data.meas_rate;
                    r_enc      <= 1'b1;
                end
                REQ_GYRO: begin
                    r_gyro_rate <= i_data.meas_rate;
                    r_gyro      <= 1'b1;
                end
                REQ_TICK: begin
                    r_enc  <= 1'b0;
                    r_gyro <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/vkf_queue.sv =====
`default_nettype none
module vkf_queue import vkf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("tick pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ===== sv/vkf_back.sv =====
`default_nettype none
module vkf_back import vkf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_cmd,
    input  wire logic i_q_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DLOAD, S_DIV, S_APPLY, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PS_PRED0, PS_PRED1, PS_QN, PS_ENC_V, PS_ENC_W, PS_GYRO
    } t_pass;

    localparam logic [2:0] P00 = 3'd0, P02 = 3'd1, P11 = 3'd2, P13 = 3'd3;
    localparam logic [2:0] P20 = 3'd4, P22 = 3'd5, P31 = 3'd6, P33 = 3'd7;
    localparam logic [5:0] DIV_LAST = 6'd63;
    localparam logic signed [67:0] GAIN_LIM = 68'sd8589934592;

    t_state             r_state;
    t_pass              r_pass;
    logic [2:0]         r_sub;
    t_cmd               r_cmd;
    logic signed [31:0] r_x [4];
    logic signed [31:0] r_p [8];
    logic signed [31:0] r_n [3];
    logic signed [33:0] r_yd;
    logic signed [39:0] r_acc;
    logic signed [33:0] r_s;
    logic signed [33:0] r_e;
    logic signed [67:0] r_prod;
    logic               r_neg;
    logic [32:0]        r_rem;
    logic [63:0]        r_quo;
    logic [5:0]         r_cnt;
    logic               r_out_valid;
    t_out               r_out;

    logic               w_pair;
    logic               w_meas;
    logic signed [31:0] w_pxx, w_pxy, w_pyx, w_pyy, w_xx, w_xy;
    logic [2:0]         w_ixx, w_ixy, w_iyx, w_iyy;
    logic [1:0]         w_xi, w_yi;
    logic [VAR_W-1:0]   w_r;
    logic signed [31:0] w_m;
    logic signed [33:0] w_a, w_b, w_d;
    logic signed [67:0] w_sh;
    logic [67:0]        w_mag;
    logic [32:0]        w_dvs;
    logic               w_dz;
    logic [33:0]        w_rsh;
    logic [33:0]        w_rdiff;
    logic signed [67:0] w_qv;
    logic signed [67:0] w_qc;
    logic signed [31:0] w_t;
    logic signed [31:0] w_nt;
    logic               w_last;
    t_pass              w_np;
    logic               w_np_done;

    assign w_pair = (r_pass == PS_PRED1) || (r_pass == PS_ENC_W) || (r_pass == PS_GYRO);
    assign w_meas = (r_pass == PS_ENC_V) || (r_pass == PS_ENC_W) || (r_pass == PS_GYRO);

    assign w_ixx = w_pair ? P11 : P00;
    assign w_ixy = w_pair ? P13 : P02;
    assign w_iyx = w_pair ? P31 : P20;
    assign w_iyy = w_pair ? P33 : P22;
    assign w_xi  = w_pair ? 2'd1 : 2'd0;
    assign w_yi  = w_pair ? 2'd3 : 2'd2;

    assign w_pxx = w_pair ? r_p[P11] : r_p[P00];
    assign w_pxy = w_pair ? r_p[P13] : r_p[P02];
    assign w_pyx = w_pair ? r_p[P31] : r_p[P20];
    assign w_pyy = w_pair ? r_p[P33] : r_p[P22];
    assign w_xx  = w_pair ? r_x[1] : r_x[0];
    assign w_xy  = w_pair ? r_x[3] : r_x[2];
    assign w_d   = 34'({17'd0, i_cfg.time_step});

    always_comb begin
        case (r_pass)
            PS_ENC_V: begin
                w_r = i_cfg.enc_noise_vel;
                w_m = r_cmd.enc_vel;
            end
            PS_ENC_W: begin
                w_r = i_cfg.enc_noise_rate;
                w_m = r_cmd.enc_rate;
            end
            default: begin
                w_r = i_cfg.gyro_noise_rate;
                w_m = r_cmd.gyro_rate;
            end
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        w_a = 34'(w_pxx);
        w_b = w_d;
        if (r_pass == PS_QN) begin
            w_a = (r_sub == 3'd0) ? 34'({3'd0, i_cfg.proc_noise_accel})
                                  : 34'({3'd0, i_cfg.proc_noise_rate_dot});
        end else if (!w_meas) begin
            case (r_sub)
                3'd0:    w_a = 34'(w_pyy);
                3'd1:    w_a = 34'(w_pyx);
                3'd2:    w_a = 34'(w_pxy);
                3'd3:    w_a = r_yd;
                3'd4:    w_a = w_pair ? 34'({3'd0, i_cfg.proc_noise_rate})
                                      : 34'({3'd0, i_cfg.proc_noise_vel});
                default: w_a = 34'(w_xy);
            endcase
        end else begin
            case (r_sub)
                3'd0: begin w_a = 34'(w_pxx); w_b = 34'(w_pxx); end
                3'd1: begin w_a = 34'(w_pxx); w_b = 34'(w_pxy); end
                3'd2: begin w_a = 34'(w_pyx); w_b = 34'(w_pxx); end
                3'd3: begin w_a = 34'(w_pyx); w_b = 34'(w_pxy); end
                3'd4: begin w_a = r_e;        w_b = 34'(w_pxx); end
                default: begin w_a = r_e;     w_b = 34'(w_pyx); end
            endcase
        end
    end

    assign w_sh  = r_prod >>> FRAC_BITS;
    assign w_mag = r_prod[67] ? 68'(-r_prod) : 68'(r_prod);

    // covariance terms divide by s, gain terms by r
    assign w_dvs = (r_sub < 3'd4) ? r_s[32:0] : {2'd0, w_r};
    assign w_dz  = (r_sub < 3'd4) ? (r_s <= 34'sd0) : (w_r == '0);

    assign w_rsh   = {r_rem, r_quo[63]};
    assign w_rdiff = w_rsh - {1'b0, w_dvs};

    always_comb begin
        if (w_dz) begin
            w_qv = '0;
        end else if (r_neg) begin
            w_qv = -$signed({4'd0, r_quo});
        end else begin
            w_qv = $signed({4'd0, r_quo});
        end
        if (w_qv > GAIN_LIM) begin
            w_qc = GAIN_LIM;
        end else if (w_qv < -GAIN_LIM) begin
            w_qc = -GAIN_LIM;
        end else begin
            w_qc = w_qv;
        end
        case (r_sub)
            3'd0:    w_t = w_pxx;
            3'd1:    w_t = w_pxy;
            3'd2:    w_t = w_pyx;
            default: w_t = w_pyy;
        endcase
        w_nt = sat32(68'(w_t) - w_qv);
    end

    always_comb begin
        w_last    = (r_pass == PS_QN) ? (r_sub == 3'd1) : (r_sub == 3'd5);
        w_np      = PS_GYRO;
        w_np_done = 1'b0;
        case (r_pass)
            PS_PRED0: w_np = PS_PRED1;
            PS_PRED1: w_np = PS_QN;
            PS_QN: begin
                if (r_cmd.enc) begin
                    w_np = PS_ENC_V;
                end else if (!r_cmd.gyro) begin
                    w_np_done = 1'b1;
                end
            end
            PS_ENC_V: w_np = PS_ENC_W;
            PS_ENC_W: w_np_done = !r_cmd.gyro;
            default:  w_np_done = 1'b1;
        endcase
    end

    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= PS_PRED0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_x[i] <= '0;
            end
            r_p[P00] <= COV_ONE;
            r_p[P02] <= '0;
            r_p[P11] <= COV_ONE;
            r_p[P13] <= '0;
            r_p[P20] <= '0;
            r_p[P22] <= COV_ONE;
            r_p[P31] <= '0;
            r_p[P33] <= COV_ONE;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_cmd;
                        r_pass  <= PS_PRED0;
                        r_sub   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_a * w_b;
                    if (w_meas && r_sub == 3'd0) begin
                        r_s <= 34'(w_pxx) + 34'({3'd0, w_r});
                        r_e <= 34'(w_m) - 34'(w_xx);
                    end
                    r_state <= w_meas ? S_DLOAD : S_APPLY;
                end
                S_DLOAD: begin
                    r_neg   <= r_prod[67];
                    r_quo   <= w_mag[63:0];
                    r_rem   <= '0;
                    r_cnt   <= DIV_LAST;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsh >= {1'b0, w_dvs}) begin
                        r_rem <= w_rdiff[32:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh[32:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (r_pass == PS_QN) begin
                        if (r_sub == 3'd0) begin
                            r_p[P22] <= cap_cov(sat32(68'(r_p[P22]) + w_sh));
                        end else begin
                            r_p[P33] <= cap_cov(sat32(68'(r_p[P33]) + w_sh));
                        end
                    end else if (!w_meas) begin
                        case (r_sub)
                            3'd0: r_yd  <= w_sh[33:0];
                            3'd1: r_acc <= 40'(w_pxx) + w_sh[39:0];
                            3'd2, 3'd3, 3'd4: r_acc <= r_acc + w_sh[39:0];
                            default: begin
                                r_x[w_xi]  <= sat32(68'(w_xx) + w_sh);
                                r_p[w_ixx] <= cap_cov(sat32(68'(r_acc)));
                                r_p[w_ixy] <= cap_cov(sat32(68'(w_pxy) + 68'(r_yd)));
                                r_p[w_iyx] <= cap_cov(sat32(68'(w_pyx) + 68'(r_yd)));
                            end
                        endcase
                    end else begin
                        case (r_sub)
                            3'd0: r_n[0] <= w_nt;
                            3'd1: r_n[1] <= w_nt;
                            3'd2: r_n[2] <= w_nt;
                            3'd3: begin
                                r_p[w_ixx] <= r_n[0];
                                r_p[w_ixy] <= r_n[1];
                                r_p[w_iyx] <= r_n[2];
                                r_p[w_iyy] <= w_nt;
                            end
                            3'd4: r_x[w_xi] <= sat32(68'(w_xx) + w_qc);
                            default: r_x[w_yi] <= sat32(68'(w_xy) + w_qc);
                        endcase
                    end
                    if (!w_last) begin
                        r_sub   <= r_sub + 3'd1;
                        r_state <= S_MUL;
                    end else if (w_np_done) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pass  <= w_np;
                        r_sub   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out <= '{est_vel: r_x[0], est_rate: r_x[1], est_accel: r_x[2],
                                   est_rate_dot: r_x[3],
                                   had_measurement: r_cmd.enc || r_cmd.gyro};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/velocity_kalman_filter_core.sv =====
`default_nettype none
// Four-state velocity Kalman filter (velocity, yaw rate, acceleration, yaw
// acceleration) in signed fixed point with FRAC_BITS fraction bits. Encoder
// and gyro sample requests are taken one per cycle and only latch the latest
// sample; a tick request is queued together with the pending samples and
// produces one estimate on the output channel. The back end runs every tick
// through one shared 34x34 multiplier and a one-bit-per-cycle restoring
// divider: prediction runs two state-pair passes and a process-noise pass,
// and each measured component (encoder velocity, encoder rate, gyro rate)
// adds a correction pass with 6 divisions. Up to two ticks wait in the queue
// while the back end is busy; the output register holds one finished
// estimate while the next tick is worked on.
// Configuration registers are written by index through a plain write port
// and must only change while no tick is in flight.
module velocity_kalman_filter_core import vkf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // sample and tick requests
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in_data,
    // estimates
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out_data,
    // configuration write port
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [VAR_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    // configuration register file, values masked to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step           <= DT_RESET;
            r_cfg.proc_noise_vel      <= VAR_RESET;
            r_cfg.proc_noise_rate     <= VAR_RESET;
            r_cfg.proc_noise_accel    <= VAR_RESET;
            r_cfg.proc_noise_rate_dot <= VAR_RESET;
            r_cfg.enc_noise_vel       <= VAR_RESET;
            r_cfg.enc_noise_rate      <= VAR_RESET;
            r_cfg.gyro_noise_rate     <= VAR_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_STEP:     r_cfg.time_step           <= i_cfg_data[DT_W-1:0];
                CFG_PROC_VEL:      r_cfg.proc_noise_vel      <= i_cfg_data;
                CFG_PROC_RATE:     r_cfg.proc_noise_rate     <= i_cfg_data;
                CFG_PROC_ACCEL:    r_cfg.proc_noise_accel    <= i_cfg_data;
                CFG_PROC_RATE_DOT: r_cfg.proc_noise_rate_dot <= i_cfg_data;
                CFG_ENC_VEL:       r_cfg.enc_noise_vel       <= i_cfg_data;
                CFG_ENC_RATE:      r_cfg.enc_noise_rate      <= i_cfg_data;
                CFG_GYRO_RATE:     r_cfg.gyro_noise_rate     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end: latches samples, queues ticks with a snapshot of them
    vkf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // short tick queue between front and back
    vkf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back end: predict and correct sequencer, owns the filter state
    vkf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (w_head_cmd),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule
`default_nettype wire
